// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the frame parser rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked property, off while reset is applied
`define SFP_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sensor frame parser check failed");

// checked property, on at every edge
`define SFP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sensor frame parser check failed");

`else

`define SFP_ASSERT_RST(label, clk, rst_n, prop)
`define SFP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- hw/rtl/sfp_pkg.sv -----
// types and constants of the sensor frame parser
// no dependencies
package sfp_pkg;

  localparam logic [7:0] SyncByte   = 8'hAC;
  localparam logic [2:0] PayloadLen = 3'd4;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_ADDR  = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_e;

  typedef struct packed {
    logic [3:0]         sensor_addr;
    logic [3:0]         seq_number;
    logic [7:0]         msg_type;
    logic signed [15:0] temperature;
    logic [15:0]        humidity;
    logic               checksum_ok;
    logic               is_new;
  } res_t;

endpackage

// ----- hw/rtl/sfp_in_reg.sv -----
// input word register of the sensor frame parser
// no package dependencies
module sfp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       vld_o,
  output logic [7:0] byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;

  // takes a new word when empty or when the held word moves on
  assign in_ready_o = !vld_q || advance_i;

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

// ----- hw/rtl/sfp_frame_fsm.sv -----
// frame hunt, capture and checksum state of the sensor frame parser
// depends on sfp_pkg and assert_macros.svh
`include "assert_macros.svh"

module sfp_frame_fsm (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  logic [7:0]   byte_i,
  output logic         res_valid_o,
  output sfp_pkg::res_t res_o
);

  import sfp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] pay_q, pay_d;
  logic [3:0]  last_seq_q, last_seq_d;
  logic [3:0]  seq;
  logic        ok;
  logic        fresh;

  assign seq   = addr_q[7:4];
  assign ok    = (byte_i == xor_q);
  assign fresh = ok && (seq != last_seq_q);

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    xor_d       = xor_q;
    addr_d      = addr_q;
    type_d      = type_q;
    pay_d       = pay_q;
    last_seq_d  = last_seq_q;
    res_valid_o = 1'b0;
    if (fire_i) begin
      case (phase_q)
        PH_SYNC2: begin
          // noise between the sync bytes is dropped without restarting
          if (byte_i == SyncByte) begin
            xor_d   = xor_q ^ byte_i;
            phase_d = PH_ADDR;
          end
        end
        PH_ADDR: begin
          addr_d  = byte_i;
          xor_d   = xor_q ^ byte_i;
          phase_d = PH_TYPE;
        end
        PH_TYPE: begin
          type_d  = byte_i;
          xor_d   = xor_q ^ byte_i;
          cnt_d   = '0;
          pay_d   = '0;
          phase_d = PH_DATA;
        end
        PH_DATA: begin
          pay_d = {pay_q[23:0], byte_i};
          xor_d = xor_q ^ byte_i;
          cnt_d = cnt_q + 3'd1;
          if (cnt_d == PayloadLen) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          res_valid_o = 1'b1;
          if (fresh) begin
            last_seq_d = seq;
          end
          xor_d   = '0;
          phase_d = PH_SYNC1;
        end
        default: begin
          // hunting for the first sync byte, also unused codes
          phase_d = PH_SYNC1;
          if (byte_i == SyncByte) begin
            xor_d   = byte_i;
            phase_d = PH_SYNC2;
          end
        end
      endcase
    end
  end

  always_comb begin
    res_o.sensor_addr = addr_q[3:0];
    res_o.seq_number  = seq;
    res_o.msg_type    = type_q;
    res_o.temperature = pay_q[31:16];
    res_o.humidity    = pay_q[15:0];
    res_o.checksum_ok = ok;
    res_o.is_new      = fresh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SYNC1;
      cnt_q      <= '0;
      xor_q      <= '0;
      addr_q     <= '0;
      type_q     <= '0;
      pay_q      <= '0;
      last_seq_q <= '0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      xor_q      <= xor_d;
      addr_q     <= addr_d;
      type_q     <= type_d;
      pay_q      <= pay_d;
      last_seq_q <= last_seq_d;
    end
  end

  // a check byte always returns to the hunt with a cleared checksum
  `SFP_ASSERT_RST(a_check_restarts, clk_i, rst_ni, fire_i && phase_q == PH_CHECK |=> phase_q == PH_SYNC1 && xor_q == 8'h00)
  // last sequence only moves on a check byte
  `SFP_ASSERT_RST(a_seq_on_check, clk_i, rst_ni, !$stable(last_seq_q) |-> $past(fire_i && phase_q == PH_CHECK))
  // payload counter never passes the payload length while capturing
  `SFP_ASSERT_ALWAYS(a_cnt_bound, clk_i, !rst_ni || phase_q != PH_DATA || cnt_q < PayloadLen)

endmodule

// ----- hw/rtl/sfp_out_reg.sv -----
// result register of the sensor frame parser
// depends on sfp_pkg
module sfp_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  sfp_pkg::res_t res_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic          room_o,
  output sfp_pkg::res_t res_o
);

  import sfp_pkg::*;

  logic vld_q, vld_d;
  res_t res_q;

  // free when empty or being drained this cycle
  assign room_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

// ----- hw/rtl/sensor_frame_parser.sv -----
// top level of the sensor frame parser
// depends on sfp_pkg, sfp_in_reg, sfp_frame_fsm, sfp_out_reg and assert_macros.svh
`include "assert_macros.svh"

// Byte-serial receiver for framed sensor reports. Each input word is one
// received byte; the parser hunts for two 0xAC sync bytes (other bytes
// between the two are ignored), captures an address byte, a type byte and
// four payload bytes while keeping a running XOR, and on the check byte
// emits one result word: sensor address and sequence number (low and high
// nibble of the address byte), type, signed temperature and unsigned
// humidity in tenths (big-endian payload), a checksum flag and a flag for a
// good frame whose sequence number differs from the last accepted one.
// Frames with a bad checksum still produce a result with both flags low.
// Throughput is one byte per clock while the output is not stalled: a byte
// sits in the input register, the frame state updates from it through short
// logic, and the result word is registered in the output register, which
// drives the outputs. The state only advances when the result register has
// room, so a stalled output back-pressures the byte input; while the result
// register is full and not being taken, at most one further byte is held.
// Every byte waits in this way, including those that produce no result.
module sensor_frame_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         sensor_addr_o,
  output logic [3:0]         seq_number_o,
  output logic [7:0]         msg_type_o,
  output logic signed [15:0] temperature_o,
  output logic [15:0]        humidity_o,
  output logic               checksum_ok_o,
  output logic               is_new_o
);

  import sfp_pkg::*;

  logic       byte_vld;
  logic [7:0] byte_q;
  logic       room;
  logic       advance;
  logic       res_valid;
  res_t       res;
  res_t       res_q;

  // a held byte moves into the frame state only if a result could be stored
  assign advance = byte_vld && room;

  sfp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .vld_o      (byte_vld),
    .byte_o     (byte_q)
  );

  sfp_frame_fsm u_frame_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .byte_i      (byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .room_o      (room),
    .res_o       (res_q)
  );

  // unpack the result word onto its field ports
  assign sensor_addr_o = res_q.sensor_addr;
  assign seq_number_o  = res_q.seq_number;
  assign msg_type_o    = res_q.msg_type;
  assign temperature_o = res_q.temperature;
  assign humidity_o    = res_q.humidity;
  assign checksum_ok_o = res_q.checksum_ok;
  assign is_new_o      = res_q.is_new;

  // a frame is only new if its checksum matched
  `SFP_ASSERT_RST(a_new_needs_ok, clk_i, rst_ni, out_valid_o |-> checksum_ok_o || !is_new_o)
  // a result is only produced when the output register can hold it
  `SFP_ASSERT_RST(a_no_overwrite, clk_i, rst_ni, res_valid |-> !out_valid_o || out_ready_i)

endmodule
